// ===== src/tccc_pkg.sv =====
// shared types and constants of the text console cursor control block
`timescale 1ns / 1ps

package tccc_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    // field widths
    localparam int POS_W   = 16;
    localparam int DIM_W   = 13;
    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 7;
    localparam int COLOR_W = 32;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // operation selector on the input
    localparam logic OP_CHAR   = 1'b0;
    localparam logic OP_SETCUR = 1'b1;

    // result kinds
    localparam logic KIND_GLYPH  = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // character codes and geometry
    localparam logic [CHAR_W-1:0] CODE_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NL  = 8'd10;
    localparam logic [POS_W:0]    LINE_H   = 17'd16;
    localparam logic [POS_W:0]    TAB_W    = 17'd32;
    localparam logic [POS_W:0]    GLYPH_W  = 17'd8;
    localparam logic [POS_W-1:0]  POS_MAX  = 16'hFFFF;

    // per-character command handed from the front to the back
    typedef struct packed {
        logic               scroll;
        logic               glyph;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] color;
    } t_cmd;

endpackage

// ===== src/tccc_front.sv =====
// front end: accepts items, keeps the cursor and classifies each character
`timescale 1ns / 1ps

module tccc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [tccc_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_op,
    input  logic [tccc_pkg::CHAR_W-1:0]  i_char,
    input  logic [tccc_pkg::COLOR_W-1:0] i_color,
    input  logic [tccc_pkg::DIM_W-1:0]   i_new_x,
    input  logic [tccc_pkg::DIM_W-1:0]   i_new_y,
    input  logic                    i_q_full,
    output logic                    o_push,
    output tccc_pkg::t_cmd          o_cmd
);
    import tccc_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic             accept;

    // saturating 16-bit add
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + b;
        return s[POS_W] ? POS_MAX : s[POS_W-1:0];
    endfunction

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // cursor update for one character
    always_comb begin
        logic             scroll;
        logic             glyph;
        logic [POS_W-1:0] col_a, row_a, col_b, row_b;
        logic [DIM_W-1:0] last_line;
        scroll    = ({1'b0, r_row} + LINE_H) > {4'b0, r_height};
        last_line = (r_height >= DIM_W'(LINE_H)) ? r_height - DIM_W'(LINE_H) : '0;
        col_a     = scroll ? '0 : r_col;
        row_a     = scroll ? {3'b0, last_line} : r_row;
        glyph     = 1'b0;
        col_b     = col_a;
        row_b     = row_a;
        case (i_char)
            CODE_NL: begin
                col_b = '0;
                row_b = sat_add(row_a, LINE_H);
            end
            CODE_TAB: begin
                col_b = sat_add(col_a, TAB_W);
            end
            default: begin
                glyph = !i_char[CHAR_W-1];
                col_b = sat_add(col_a, GLYPH_W);
            end
        endcase
        // wrap when a further glyph would pass the width
        if (({1'b0, col_b} + GLYPH_W) > {4'b0, r_width}) begin
            col_b = '0;
            row_b = sat_add(row_b, LINE_H);
        end

        o_cmd.scroll = scroll;
        o_cmd.glyph  = glyph;
        o_cmd.x      = col_a;
        o_cmd.y      = row_a;
        o_cmd.code   = i_char[CODE_W-1:0];
        o_cmd.color  = i_color;

        n_col  = r_col;
        n_row  = r_row;
        o_push = 1'b0;
        if (accept) begin
            if (i_op == OP_SETCUR) begin
                n_col = {3'b0, i_new_x};
                n_row = {3'b0, i_new_y};
            end else if (i_char != CODE_NUL) begin
                n_col  = col_b;
                n_row  = row_b;
                // only characters that cause a result go to the back
                o_push = scroll || glyph;
            end
        end
    end

    // cursor and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_width  <= 13'd640;
            r_height <= 13'd480;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WIDTH:  r_width  <= i_cfg_wdata;
                    CFG_HEIGHT: r_height <= i_cfg_wdata;
                    default:    r_width  <= r_width;
                endcase
            end
        end
    end

endmodule

// ===== src/tccc_queue.sv =====
// short command queue between the front and the back
`timescale 1ns / 1ps

module tccc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tccc_pkg::t_cmd o_head
);
    import tccc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/tccc_back.sv =====
// back end: turns queued commands into scroll and glyph transfers
`timescale 1ns / 1ps

module tccc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tccc_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [tccc_pkg::POS_W-1:0]   o_x,
    output logic [tccc_pkg::POS_W-1:0]   o_y,
    output logic [tccc_pkg::CODE_W-1:0]  o_code,
    output logic [tccc_pkg::COLOR_W-1:0] o_color,
    output logic           o_last
);
    import tccc_pkg::*;

    logic               r_valid, n_valid;
    logic               r_half, n_half;
    logic               r_kind, n_kind;
    logic [POS_W-1:0]   r_x, n_x, r_y, n_y;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_last, n_last;
    logic               load;

    assign load = !r_valid || i_ready;

    // scroll goes out first; the head stays until its glyph has gone too
    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        n_kind  = r_kind;
        n_x     = r_x;
        n_y     = r_y;
        n_code  = r_code;
        n_color = r_color;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.scroll && !r_half) begin
                    n_kind  = KIND_SCROLL;
                    n_x     = '0;
                    n_y     = '0;
                    n_code  = '0;
                    n_color = '0;
                    n_last  = !i_head.glyph;
                    n_half  = i_head.glyph;
                    o_pop   = !i_head.glyph;
                end else begin
                    n_kind  = KIND_GLYPH;
                    n_x     = i_head.x;
                    n_y     = i_head.y;
                    n_code  = i_head.code;
                    n_color = i_head.color;
                    n_last  = 1'b1;
                    n_half  = 1'b0;
                    o_pop   = 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
        r_kind  <= n_kind;
        r_x     <= n_x;
        r_y     <= n_y;
        r_code  <= n_code;
        r_color <= n_color;
        r_last  <= n_last;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_code  = r_code;
    assign o_color = r_color;
    assign o_last  = r_last;

endmodule

// ===== src/text_console_cursor_control.sv =====
// top level of the text console cursor control block
//
// channel   dir  handshake           payload
// s_axis    in   tvalid/tready       tdata: char_code, color, new_x, new_y; tuser: op
// m_axis    out  tvalid/tready       tdata: glyph_x, glyph_y, glyph_code, glyph_color;
//                                    tuser: kind; tlast: last
// cfg       in   i_cfg_we            i_cfg_addr, i_cfg_wdata
//
// one item is taken per cycle while the command queue has room; the cursor
// update is done in the cycle of the transfer
// the output register sends one result per cycle while m_axis_tready is high, so a character that scrolls
// and draws holds the back for a scroll result and then a glyph result; queue depth absorbs such bursts
// a result passes through the command queue and then the output register
// synchronous active-low reset clears cursor, queue and output valid and
// loads the screen size to 640 by 480
`timescale 1ns / 1ps

module text_console_cursor_control #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [tccc_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], color[39:8], new_x[52:40], new_y[65:53], zero[71:66]
    input  logic [tccc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // glyph_x[15:0], glyph_y[31:16], glyph_code[38:32], glyph_color[70:39], zero[71]
    output logic [tccc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import tccc_pkg::*;

    t_cmd               push_cmd, head_cmd;
    logic               push, pop, q_full, q_empty;
    logic [POS_W-1:0]   out_x, out_y;
    logic [CODE_W-1:0]  out_code;
    logic [COLOR_W-1:0] out_color;

    tccc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_char     (s_axis_tdata[7:0]),
        .i_color    (s_axis_tdata[39:8]),
        .i_new_x    (s_axis_tdata[52:40]),
        .i_new_y    (s_axis_tdata[65:53]),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tccc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_head (head_cmd)
    );

    tccc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(q_empty),
        .i_head (head_cmd),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_kind (m_axis_tuser),
        .o_x    (out_x),
        .o_y    (out_y),
        .o_code (out_code),
        .o_color(out_color),
        .o_last (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_color, out_code, out_y, out_x};

endmodule

// ===== src/tccc_checker.sv =====
// port-level assertions for the text console cursor control block
`timescale 1ns / 1ps

module tccc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [tccc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import tccc_pkg::*;

    // output stays up until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // scroll commands carry an all-zero payload
    a_scroll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SCROLL |-> m_axis_tdata == '0)
        else $error("scroll command with payload");

    // a glyph is always the final result of its character
    a_glyph_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_GLYPH |-> m_axis_tlast)
        else $error("glyph not marked last");

    // a scroll that is not last is followed at once by its glyph
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tuser == KIND_GLYPH)
        else $error("scroll not followed by its glyph");

endmodule

bind text_console_cursor_control tccc_checker u_tccc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
